// File: rtl/core/tfcm_pkg.sv
// ----------------------------------------------------------------------------
// tfcm_pkg: shared definitions of the thermal false-color mapper
// Field widths, register codes, reset values, command bundle and the
// RGB565 palette ROM contents.
// ----------------------------------------------------------------------------
package tfcm_pkg;

	localparam int TEMP_W   = 13;
	localparam int POS_W    = 6;
	localparam int DEG_W    = 8;
	localparam int GRID_W   = 7;
	localparam int COLOR_W  = 16;
	localparam int COORD_W  = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	localparam int GRID_MAX_DEF      = 64;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int COUNTER_LIMIT     = 64;

	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DEG_W-1:0]   RST_MIN_TEMP   = 8'd20;
	localparam logic [DEG_W-1:0]   RST_MAX_TEMP   = 8'd28;
	localparam logic [GRID_W-1:0]  RST_GRID_COLS  = 7'd8;
	localparam logic [GRID_W-1:0]  RST_GRID_ROWS  = 7'd8;
	localparam logic [DEG_W-1:0]   RST_BOX_WIDTH  = 8'd10;
	localparam logic [DEG_W-1:0]   RST_BOX_HEIGHT = 8'd16;

	localparam logic [14:0]        X_ORIGIN  = 15'd40;
	localparam logic [COORD_W-1:0] COORD_MAX = 10'd1023;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd5;

	typedef struct packed {
		logic capture;
		logic load;
		logic div_step;
		logic result_write;
	} tfcm_cmd_t;

	localparam logic [COLOR_W-1:0] PALETTE_ROM [0:255] = '{
		16'h480F,
		16'h400F, 16'h400F, 16'h400F, 16'h4010, 16'h3810, 16'h3810, 16'h3810, 16'h3810,
		16'h3010, 16'h3010,
		16'h3010, 16'h2810, 16'h2810, 16'h2810, 16'h2810, 16'h2010, 16'h2010, 16'h2010,
		16'h1810, 16'h1810,
		16'h1811, 16'h1811, 16'h1011, 16'h1011, 16'h1011, 16'h0811, 16'h0811, 16'h0811,
		16'h0011, 16'h0011,
		16'h0011, 16'h0011, 16'h0011, 16'h0031, 16'h0031, 16'h0051, 16'h0072, 16'h0072,
		16'h0092, 16'h00B2,
		16'h00B2, 16'h00D2, 16'h00F2, 16'h00F2, 16'h0112, 16'h0132, 16'h0152, 16'h0152,
		16'h0172, 16'h0192,
		16'h0192, 16'h01B2, 16'h01D2, 16'h01F3, 16'h01F3, 16'h0213, 16'h0233, 16'h0253,
		16'h0253, 16'h0273,
		16'h0293, 16'h02B3, 16'h02D3, 16'h02D3, 16'h02F3, 16'h0313, 16'h0333, 16'h0333,
		16'h0353, 16'h0373,
		16'h0394, 16'h03B4, 16'h03D4, 16'h03D4, 16'h03F4, 16'h0414, 16'h0434, 16'h0454,
		16'h0474, 16'h0474,
		16'h0494, 16'h04B4, 16'h04D4, 16'h04F4, 16'h0514, 16'h0534, 16'h0534, 16'h0554,
		16'h0554, 16'h0574,
		16'h0574, 16'h0573, 16'h0573, 16'h0573, 16'h0572, 16'h0572, 16'h0572, 16'h0571,
		16'h0591, 16'h0591,
		16'h0590, 16'h0590, 16'h058F, 16'h058F, 16'h058F, 16'h058E, 16'h05AE, 16'h05AE,
		16'h05AD, 16'h05AD,
		16'h05AD, 16'h05AC, 16'h05AC, 16'h05AB, 16'h05CB, 16'h05CB, 16'h05CA, 16'h05CA,
		16'h05CA, 16'h05C9,
		16'h05C9, 16'h05C8, 16'h05E8, 16'h05E8, 16'h05E7, 16'h05E7, 16'h05E6, 16'h05E6,
		16'h05E6, 16'h05E5,
		16'h05E5, 16'h0604, 16'h0604, 16'h0604, 16'h0603, 16'h0603, 16'h0602, 16'h0602,
		16'h0601, 16'h0621,
		16'h0621, 16'h0620, 16'h0620, 16'h0620, 16'h0620, 16'h0E20, 16'h0E20, 16'h0E40,
		16'h1640, 16'h1640,
		16'h1E40, 16'h1E40, 16'h2640, 16'h2640, 16'h2E40, 16'h2E60, 16'h3660, 16'h3660,
		16'h3E60, 16'h3E60,
		16'h3E60, 16'h4660, 16'h4660, 16'h4E60, 16'h4E80, 16'h5680, 16'h5680, 16'h5E80,
		16'h5E80, 16'h6680,
		16'h6680, 16'h6E80, 16'h6EA0, 16'h76A0, 16'h76A0, 16'h7EA0, 16'h7EA0, 16'h86A0,
		16'h86A0, 16'h8EA0,
		16'h8EC0, 16'h96C0, 16'h96C0, 16'h9EC0, 16'h9EC0, 16'hA6C0, 16'hAEC0, 16'hAEC0,
		16'hB6E0, 16'hB6E0,
		16'hBEE0, 16'hBEE0, 16'hC6E0, 16'hC6E0, 16'hCEE0, 16'hCEE0, 16'hD6E0, 16'hD700,
		16'hDF00, 16'hDEE0,
		16'hDEC0, 16'hDEA0, 16'hDE80, 16'hDE80, 16'hE660, 16'hE640, 16'hE620, 16'hE600,
		16'hE5E0, 16'hE5C0,
		16'hE5A0, 16'hE580, 16'hE560, 16'hE540, 16'hE520, 16'hE500, 16'hE4E0, 16'hE4C0,
		16'hE4A0, 16'hE480,
		16'hE460, 16'hEC40, 16'hEC20, 16'hEC00, 16'hEBE0, 16'hEBC0, 16'hEBA0, 16'hEB80,
		16'hEB60, 16'hEB40,
		16'hEB20, 16'hEB00, 16'hEAE0, 16'hEAC0, 16'hEAA0, 16'hEA80, 16'hEA60, 16'hEA40,
		16'hF220, 16'hF200,
		16'hF1E0, 16'hF1C0, 16'hF1A0, 16'hF180, 16'hF160, 16'hF140, 16'hF100, 16'hF0E0,
		16'hF0C0, 16'hF0A0,
		16'hF080, 16'hF060, 16'hF040, 16'hF020, 16'hF800
	};

endpackage

// File: rtl/core/tfcm_ctrl.sv
// ----------------------------------------------------------------------------
// tfcm_ctrl: sequencer of the false-color mapper
// Accepts one sample at a time, steps the datapath through load, eight
// divide iterations and result write, and owns both handshakes.
// ----------------------------------------------------------------------------
module tfcm_ctrl
	import tfcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output tfcm_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  in_ready_q;
	logic                  out_valid_q;
	logic                  can_write;

	// The output register is free when empty or being drained this cycle.
	assign can_write = !out_valid_q || out_ready;

	always_comb begin
		cmd.capture      = in_valid && in_ready_q;
		cmd.load         = (state_q == S_LOAD);
		cmd.div_step     = (state_q == S_DIV);
		cmd.result_write = (state_q == S_DONE) && can_write;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_write) begin
						out_valid_q <= 1'b1;
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/tfcm_dp.sv
// ----------------------------------------------------------------------------
// tfcm_dp: datapath of the false-color mapper
// Holds the configuration registers, frame counters and running extremes,
// scales the clamped sample with a shift-subtract divider and drives the
// result register.
// ----------------------------------------------------------------------------
module tfcm_dp
	import tfcm_pkg::*;
#(
	parameter int GRID_MAX      = GRID_MAX_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfcm_cmd_t                   cmd,
	input  logic                        cfg_write,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic signed [TEMP_W-1:0]    temp_sixteenths,
	input  logic                        frame_start,
	output logic [COLOR_W-1:0]          pixel_color,
	output logic [COORD_W-1:0]          box_x,
	output logic [COORD_W-1:0]          box_y,
	output logic signed [TEMP_W-1:0]    hottest_temp,
	output logic [POS_W-1:0]            hottest_col,
	output logic [POS_W-1:0]            hottest_row,
	output logic signed [TEMP_W-1:0]    coldest_temp,
	output logic [POS_W-1:0]            coldest_col,
	output logic [POS_W-1:0]            coldest_row,
	output logic                        frame_end
);

	localparam int GRID_LIM_A = (GRID_MAX > COUNTER_LIMIT) ? COUNTER_LIMIT : GRID_MAX;
	localparam int GRID_LIM   = (GRID_LIM_A < 1) ? 1 : GRID_LIM_A;
	localparam logic [8:0] IDX_TOP = 9'(PALETTE_DEPTH - 1);

	// Configuration registers.
	logic [DEG_W-1:0]  min_temp_q, max_temp_q, box_width_q, box_height_q;
	logic [GRID_W-1:0] grid_cols_q, grid_rows_q;

	// Captured sample.
	logic signed [TEMP_W-1:0] temp_q;
	logic                     fs_q;

	// Frame position and running extremes.
	logic [POS_W-1:0]         col_q, row_q;
	logic signed [TEMP_W-1:0] hot_val_q, cold_val_q;
	logic [POS_W-1:0]         hot_col_q, hot_row_q, cold_col_q, cold_row_q;

	// Per-sample results waiting for the divider.
	logic [14:0]       bx_s1;
	logic [13:0]       by_s1;
	logic              fend_s1;
	logic              empty_s1;
	logic [DEG_W-1:0]  dvs_q, rem_q, quo_q;

	// Load-step logic.
	logic signed [TEMP_W-1:0] lo, hi, t_cl, hot_eff, cold_eff;
	logic [POS_W-1:0]         col_eff, row_eff;
	logic [GRID_W-1:0]        ncols, nrows;
	logic                     last_col, last_row;
	logic [DEG_W-1:0]         deg, num;
	logic [15:0]              dividend;

	// Divide-step and output logic.
	logic [8:0]       trial, trial_sub;
	logic             ge;
	logic [DEG_W-1:0] idx, idx_sat;

	always_comb begin
		lo       = signed'({1'b0, min_temp_q, 4'b0000});
		hi       = signed'({1'b0, max_temp_q, 4'b0000});
		hot_eff  = fs_q ? lo : hot_val_q;
		cold_eff = fs_q ? hi : cold_val_q;
		col_eff  = fs_q ? '0 : col_q;
		row_eff  = fs_q ? '0 : row_q;

		if (temp_q < lo) begin
			t_cl = lo;
		end else if (temp_q > hi) begin
			t_cl = hi;
		end else begin
			t_cl = temp_q;
		end

		// The clamped value is never negative, so its degree part is bits 11:4.
		deg      = t_cl[11:4];
		num      = (deg > min_temp_q) ? deg - min_temp_q : '0;
		dividend = {num, 8'h00} - {8'h00, num};

		if (grid_cols_q == '0) begin
			ncols = 7'd1;
		end else if (grid_cols_q > GRID_W'(GRID_LIM)) begin
			ncols = GRID_W'(GRID_LIM);
		end else begin
			ncols = grid_cols_q;
		end
		if (grid_rows_q == '0) begin
			nrows = 7'd1;
		end else if (grid_rows_q > GRID_W'(GRID_LIM)) begin
			nrows = GRID_W'(GRID_LIM);
		end else begin
			nrows = grid_rows_q;
		end
		last_col = ({1'b0, col_eff} + 7'd1) >= ncols;
		last_row = ({1'b0, row_eff} + 7'd1) >= nrows;

		trial     = {rem_q, quo_q[DEG_W-1]};
		ge        = trial >= {1'b0, dvs_q};
		trial_sub = trial - {1'b0, dvs_q};

		idx     = empty_s1 ? '0 : quo_q;
		idx_sat = ({1'b0, idx} > IDX_TOP) ? IDX_TOP[DEG_W-1:0] : idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q   <= RST_MIN_TEMP;
			max_temp_q   <= RST_MAX_TEMP;
			grid_cols_q  <= RST_GRID_COLS;
			grid_rows_q  <= RST_GRID_ROWS;
			box_width_q  <= RST_BOX_WIDTH;
			box_height_q <= RST_BOX_HEIGHT;
			col_q        <= '0;
			row_q        <= '0;
			hot_val_q    <= signed'({1'b0, RST_MIN_TEMP, 4'b0000});
			cold_val_q   <= signed'({1'b0, RST_MAX_TEMP, 4'b0000});
			hot_col_q    <= '0;
			hot_row_q    <= '0;
			cold_col_q   <= '0;
			cold_row_q   <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_MIN_TEMP:   min_temp_q   <= cfg_data;
					REG_MAX_TEMP:   max_temp_q   <= cfg_data;
					REG_GRID_COLS:  grid_cols_q  <= cfg_data[GRID_W-1:0];
					REG_GRID_ROWS:  grid_rows_q  <= cfg_data[GRID_W-1:0];
					REG_BOX_WIDTH:  box_width_q  <= cfg_data;
					REG_BOX_HEIGHT: box_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				// A strictly hotter sample wins; only otherwise is the cold side checked.
				if (t_cl > hot_eff) begin
					hot_val_q  <= t_cl;
					hot_col_q  <= col_eff;
					hot_row_q  <= row_eff;
					cold_val_q <= cold_eff;
					cold_col_q <= fs_q ? '0 : cold_col_q;
					cold_row_q <= fs_q ? '0 : cold_row_q;
				end else if (t_cl < cold_eff) begin
					hot_val_q  <= hot_eff;
					hot_col_q  <= fs_q ? '0 : hot_col_q;
					hot_row_q  <= fs_q ? '0 : hot_row_q;
					cold_val_q <= t_cl;
					cold_col_q <= col_eff;
					cold_row_q <= row_eff;
				end else begin
					hot_val_q  <= hot_eff;
					hot_col_q  <= fs_q ? '0 : hot_col_q;
					hot_row_q  <= fs_q ? '0 : hot_row_q;
					cold_val_q <= cold_eff;
					cold_col_q <= fs_q ? '0 : cold_col_q;
					cold_row_q <= fs_q ? '0 : cold_row_q;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_eff + 1'b1;
				end else begin
					col_q <= col_eff + 1'b1;
					row_q <= row_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			temp_q <= temp_sixteenths;
			fs_q   <= frame_start;
		end
		if (cmd.load) begin
			bx_s1    <= 15'(box_width_q * col_eff) + X_ORIGIN;
			by_s1    <= 14'(box_height_q * row_eff);
			fend_s1  <= last_col && last_row;
			empty_s1 <= max_temp_q <= min_temp_q;
			dvs_q    <= max_temp_q - min_temp_q;
			// The quotient never exceeds 255, so the upper byte starts below the divisor.
			rem_q    <= dividend[15:8];
			quo_q    <= dividend[7:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[DEG_W-1:0] : trial[DEG_W-1:0];
			quo_q <= {quo_q[DEG_W-2:0], ge};
		end
		if (cmd.result_write) begin
			pixel_color  <= PALETTE_ROM[idx_sat];
			box_x        <= (bx_s1 > 15'(COORD_MAX)) ? COORD_MAX : bx_s1[COORD_W-1:0];
			box_y        <= (by_s1 > 14'(COORD_MAX)) ? COORD_MAX : by_s1[COORD_W-1:0];
			hottest_temp <= hot_val_q;
			hottest_col  <= hot_col_q;
			hottest_row  <= hot_row_q;
			coldest_temp <= cold_val_q;
			coldest_col  <= cold_col_q;
			coldest_row  <= cold_row_q;
			frame_end    <= fend_s1;
		end
	end

endmodule

// File: rtl/core/thermal_false_color_mapper_top.sv
// ----------------------------------------------------------------------------
// A sample runs through load, the eight-step shift-subtract palette scaler
// and result write; a new sample is taken only after that write.
// A finished result waits in the output register while the next sample runs.
// Reset (arst_n low) clears counters and extreme positions, loads register and extreme defaults.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// thermal_false_color_mapper_top: thermal false-color mapper
// Maps temperature samples to RGB565 palette colors with box coordinates,
// running extremes and an end-of-frame mark.
// ----------------------------------------------------------------------------
module thermal_false_color_mapper_top
	import tfcm_pkg::*;
#(
	parameter int GRID_MAX      = GRID_MAX_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TEMP_W-1:0] temp_sixteenths,
	input  logic                     frame_start,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COLOR_W-1:0]       pixel_color,
	output logic [COORD_W-1:0]       box_x,
	output logic [COORD_W-1:0]       box_y,
	output logic signed [TEMP_W-1:0] hottest_temp,
	output logic [POS_W-1:0]         hottest_col,
	output logic [POS_W-1:0]         hottest_row,
	output logic signed [TEMP_W-1:0] coldest_temp,
	output logic [POS_W-1:0]         coldest_col,
	output logic [POS_W-1:0]         coldest_row,
	output logic                     frame_end,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data
);

	tfcm_cmd_t cmd;

	// The user keeps register writes to idle; not enforced, they are always taken.
	assign cfg_ready = 1'b1;

	tfcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tfcm_dp #(
		.GRID_MAX      (GRID_MAX),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.temp_sixteenths (temp_sixteenths),
		.frame_start     (frame_start),
		.pixel_color     (pixel_color),
		.box_x           (box_x),
		.box_y           (box_y),
		.hottest_temp    (hottest_temp),
		.hottest_col     (hottest_col),
		.hottest_row     (hottest_row),
		.coldest_temp    (coldest_temp),
		.coldest_col     (coldest_col),
		.coldest_row     (coldest_row),
		.frame_end       (frame_end)
	);

endmodule
